// ===== rtl/fixed_point_alu_q24_8_core_macros.svh =====
// Assertion macros shared by the fixed-point ALU RTL.
// Depends on nothing; the asserting scope provides clk and rst_n.
`ifndef FIXED_POINT_ALU_Q24_8_CORE_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed-point ALU assertion failed");
`define FPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed-point ALU assertion failed");
`else
`define FPA_ASSERT_IMPLY(name, ante, cons)
`define FPA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/fpa_pkg.sv =====
// Package for the fixed-point ALU: opcodes, word types and the control record of the divider row.
// Depends on nothing.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam logic [4:0] OP_ADD      = 5'd0;
    localparam logic [4:0] OP_SUB      = 5'd1;
    localparam logic [4:0] OP_NEG      = 5'd2;
    localparam logic [4:0] OP_MUL      = 5'd3;
    localparam logic [4:0] OP_DIV      = 5'd4;
    localparam logic [4:0] OP_GT       = 5'd5;
    localparam logic [4:0] OP_GE       = 5'd6;
    localparam logic [4:0] OP_LT       = 5'd7;
    localparam logic [4:0] OP_LE       = 5'd8;
    localparam logic [4:0] OP_EQ       = 5'd9;
    localparam logic [4:0] OP_NE       = 5'd10;
    localparam logic [4:0] OP_MIN      = 5'd11;
    localparam logic [4:0] OP_MAX      = 5'd12;
    localparam logic [4:0] OP_INC      = 5'd13;
    localparam logic [4:0] OP_DEC      = 5'd14;
    localparam logic [4:0] OP_FROM_INT = 5'd15;
    localparam logic [4:0] OP_TO_INT   = 5'd16;

    typedef struct packed {
        logic [4:0]         cmd;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               compare_true;
        logic               divide_by_zero;
    } out_word_t;

    typedef struct packed {
        logic               valid;
        logic               is_div;
        logic               div_zero;
        logic               q_neg;
        logic               compare_true;
        logic signed [31:0] result;
    } ctl_t;

endpackage

// ===== rtl/fpa_front.sv =====
// Entry stage of the fixed-point ALU: all single-step operations, the multiplier and divider setup.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    localparam int DW = 32 + FRAC_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          take,
    input  in_word_t      word,
    output ctl_t          ctl,
    output logic [31:0]   rem,
    output logic [DW-1:0] dq,
    output logic [31:0]   dvs
);

    localparam logic [31:0] FracMask = (32'd1 << FRAC_BITS) - 32'd1;

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] prod;
    logic signed [31:0] a_adj;
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    ctl_t               ctl_reg;
    ctl_t               ctl_next;
    logic [DW-1:0]      dq_reg;
    logic [31:0]        dvs_reg;

    assign a     = word.operand_a;
    assign b     = word.operand_b;
    assign prod  = a * b;
    assign a_adj = a + (a[31] ? $signed(FracMask) : 32'sd0);
    assign a_mag = a[31] ? (32'd0 - a) : a;
    assign b_mag = b[31] ? (32'd0 - b) : b;

    always_comb
    begin
        ctl_next              = '0;
        ctl_next.valid        = take;
        ctl_next.is_div       = (word.cmd == OP_DIV);
        ctl_next.div_zero     = (word.cmd == OP_DIV) && (b == 32'sd0);
        ctl_next.q_neg        = a[31] ^ b[31];
        unique case (word.cmd)
            OP_ADD:      ctl_next.result = a + b;
            OP_SUB:      ctl_next.result = a - b;
            OP_NEG:      ctl_next.result = -a;
            OP_MUL:      ctl_next.result = prod[FRAC_BITS +: 32];
            OP_GT:       ctl_next.compare_true = (a > b);
            OP_GE:       ctl_next.compare_true = (a >= b);
            OP_LT:       ctl_next.compare_true = (a < b);
            OP_LE:       ctl_next.compare_true = (a <= b);
            OP_EQ:       ctl_next.compare_true = (a == b);
            OP_NE:       ctl_next.compare_true = (a != b);
            OP_MIN:      ctl_next.result = (a < b) ? a : b;
            OP_MAX:      ctl_next.result = (a < b) ? b : a;
            OP_INC:      ctl_next.result = a + 32'sd1;
            OP_DEC:      ctl_next.result = a - 32'sd1;
            OP_FROM_INT: ctl_next.result = a <<< FRAC_BITS;
            OP_TO_INT:   ctl_next.result = a_adj >>> FRAC_BITS;
            default:     ctl_next.result = 32'sd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            dq_reg  <= '0;
            dvs_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
            dq_reg  <= {a_mag, {FRAC_BITS{1'b0}}};
            dvs_reg <= b_mag;
        end
    end

    assign ctl = ctl_reg;
    assign rem = 32'd0;
    assign dq  = dq_reg;
    assign dvs = dvs_reg;

endmodule

// ===== rtl/fpa_div_cell.sv =====
// One cell of the divider row: a restoring step that yields one quotient bit.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_div_cell
    import fpa_pkg::*;
#(
    parameter int DW = 40
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  ctl_t          ctl_in,
    input  logic [31:0]   rem_in,
    input  logic [DW-1:0] dq_in,
    input  logic [31:0]   dvs_in,
    output ctl_t          ctl_out,
    output logic [31:0]   rem_out,
    output logic [DW-1:0] dq_out,
    output logic [31:0]   dvs_out
);

    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          q_bit;
    ctl_t          ctl_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   rem_next;
    logic [DW-1:0] dq_reg;
    logic [DW-1:0] dq_next;
    logic [31:0]   dvs_reg;

    assign trial    = {rem_in, dq_in[DW-1]};
    assign diff     = trial - {1'b0, dvs_in};
    assign q_bit    = (trial >= {1'b0, dvs_in});
    assign rem_next = q_bit ? diff[31:0] : trial[31:0];
    assign dq_next  = {dq_in[DW-2:0], q_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            rem_reg <= '0;
            dq_reg  <= '0;
            dvs_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            dvs_reg <= dvs_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;
    assign dvs_out = dvs_reg;

endmodule

// ===== rtl/fpa_out_buf.sv =====
// Result stage: final quotient sign and selection, output register and skid register.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_out_buf
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  logic [31:0] quot,
    output logic        advance,
    output logic        valid,
    input  logic        stall,
    output out_word_t   word
);

    out_word_t fin;
    out_word_t out_word_reg;
    out_word_t out_word_next;
    out_word_t skid_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    logic      take;
    logic      load_out;

    always_comb
    begin
        fin = '0;
        fin.compare_true = ctl.compare_true;
        if (ctl.is_div)
        begin
            fin.divide_by_zero = ctl.div_zero;
            if (ctl.div_zero)
            begin
                fin.result = 32'sd0;
            end
            else
            begin
                fin.result = ctl.q_neg ? $signed(32'd0 - quot) : $signed(quot);
            end
        end
        else
        begin
            fin.result = ctl.result;
        end
    end

    assign advance  = !skid_valid_reg;
    assign take     = ctl.valid && advance;
    assign load_out = !out_valid_reg || !stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        priority if (load_out && skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
            out_word_next   = skid_word_reg;
        end
        else if (load_out)
        begin
            out_valid_next = take;
            out_word_next  = fin;
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
        end
        else
        begin
            skid_valid_next = skid_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (!load_out && take)
        begin
            skid_word_reg <= fin;
        end
    end

    assign valid = out_valid_reg;
    assign word  = out_word_reg;

endmodule

// ===== rtl/fixed_point_alu_q24_8_core.sv =====
// Signed fixed-point ALU (Q24.8 for FRAC_BITS = 8): one result word for every operation word,
// one word per clock cycle while nothing stalls. A word passes through one entry stage, a row
// of 32 + FRAC_BITS divider cells that each produce one quotient bit, and the output register.
// Every operation travels the whole row, so results leave in order; the input stalls only
// while the skid register in front of the output holds a word.
// Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_out_buf and the assertion macro header.
`timescale 1ns / 1ps
`include "fixed_point_alu_q24_8_core_macros.svh"
module fixed_point_alu_q24_8_core
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_stall,
    input  in_word_t  op_word,
    output logic      res_valid,
    input  logic      res_stall,
    output out_word_t res_word
);

    localparam int DW = 32 + FRAC_BITS;

    logic          advance;
    ctl_t          ctl_chain [0:DW];
    logic [31:0]   rem_chain [0:DW];
    logic [DW-1:0] dq_chain  [0:DW];
    logic [31:0]   dvs_chain [0:DW];

    assign op_stall = !advance;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .take    (op_valid),
        .word    (op_word),
        .ctl     (ctl_chain[0]),
        .rem     (rem_chain[0]),
        .dq      (dq_chain[0]),
        .dvs     (dvs_chain[0])
    );

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        fpa_div_cell #(
            .DW (DW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctl_in  (ctl_chain[i]),
            .rem_in  (rem_chain[i]),
            .dq_in   (dq_chain[i]),
            .dvs_in  (dvs_chain[i]),
            .ctl_out (ctl_chain[i+1]),
            .rem_out (rem_chain[i+1]),
            .dq_out  (dq_chain[i+1]),
            .dvs_out (dvs_chain[i+1])
        );
    end

    fpa_out_buf u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_chain[DW]),
        .quot    (dq_chain[DW][31:0]),
        .advance (advance),
        .valid   (res_valid),
        .stall   (res_stall),
        .word    (res_word)
    );

    `FPA_ASSERT_IMPLY(a_stall_needs_result, op_stall, res_valid)
    `FPA_ASSERT_NEXT(a_accept_enters_row, op_valid && !op_stall, ctl_chain[0].valid)
    `FPA_ASSERT_IMPLY(a_div_zero_clean, res_valid && res_word.divide_by_zero, res_word.result == 32'sd0 && !res_word.compare_true)
    `FPA_ASSERT_IMPLY(a_row_holds_on_stall, !advance && ctl_chain[DW].valid, op_stall && res_valid && $past(res_valid))

endmodule

// ===== bench/fixed_point_alu_q24_8_core_tb.sv =====
// Self-checking bench for the Q24.8 fixed-point ALU core: directed table, then random words.
// Depends on fpa_pkg and fixed_point_alu_q24_8_core; results are checked in order.
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_core_tb;
    import fpa_pkg::*;

    localparam int FRAC = 8;
    localparam longint FIX_ONE = longint'(1) << FRAC;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [4:0] OP_UNUSED_LO = 5'd17;
    localparam logic [4:0] OP_UNUSED_HI = 5'd31;
    localparam out_word_t ZERO_WORD = '0;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_WORDS = 900;
    localparam int QUIET_FROM = 750;
    localparam int FLUSH_CYCLES = 64;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        in_word_t  op;
        logic      typed;
        out_word_t want;
    } stim_row_t;

    // Rows with a typed result carry it; the rest take the predictor's answer.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_ADD, S32_MAX, 32'sd1}, 1'b1, '{S32_MIN, 1'b0, 1'b0}},
        '{'{OP_SUB, S32_MIN, 32'sd1}, 1'b1, '{S32_MAX, 1'b0, 1'b0}},
        '{'{OP_NEG, S32_MIN, 32'sd0}, 1'b1, '{S32_MIN, 1'b0, 1'b0}},
        '{'{OP_MUL, S32_MAX, S32_MAX}, 1'b0, ZERO_WORD},
        '{'{OP_MUL, -32'sd384, 32'sd256}, 1'b0, ZERO_WORD},
        '{'{OP_MUL, -32'sd1, 32'sd1}, 1'b1, '{-32'sd1, 1'b0, 1'b0}},
        '{'{OP_DIV, 32'sd1234, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 1'b1}},
        '{'{OP_DIV, S32_MIN, -32'sd1}, 1'b0, ZERO_WORD},
        '{'{OP_DIV, S32_MAX, 32'sd1}, 1'b0, ZERO_WORD},
        '{'{OP_DIV, -32'sd768, 32'sd512}, 1'b0, ZERO_WORD},
        '{'{OP_GT, S32_MAX, S32_MIN}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{OP_GE, 32'sd5, 32'sd5}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{OP_LT, S32_MIN, S32_MAX}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{OP_LE, 32'sd6, 32'sd5}, 1'b1, '{32'sd0, 1'b0, 1'b0}},
        '{'{OP_EQ, -32'sd1, -32'sd1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{OP_NE, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 1'b0}},
        '{'{OP_MIN, 32'sd7, 32'sd7}, 1'b0, ZERO_WORD},
        '{'{OP_MAX, S32_MIN, S32_MAX}, 1'b1, '{S32_MAX, 1'b0, 1'b0}},
        '{'{OP_INC, S32_MAX, 32'sd0}, 1'b1, '{S32_MIN, 1'b0, 1'b0}},
        '{'{OP_DEC, S32_MIN, 32'sd0}, 1'b1, '{S32_MAX, 1'b0, 1'b0}},
        '{'{OP_FROM_INT, 32'sh0080_0000, 32'sd0}, 1'b1, '{S32_MIN, 1'b0, 1'b0}},
        '{'{OP_TO_INT, -32'sd384, 32'sd0}, 1'b0, ZERO_WORD},
        '{'{OP_TO_INT, S32_MIN, 32'sd0}, 1'b1, '{32'shFF80_0000, 1'b0, 1'b0}},
        '{'{OP_UNUSED_HI, S32_MAX, S32_MAX}, 1'b1, ZERO_WORD},
        '{'{OP_UNUSED_LO, S32_MIN, -32'sd1}, 1'b1, ZERO_WORD}
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      op_valid;
    logic      op_stall;
    in_word_t  op_word;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_word_t res_word;

    out_word_t   pending_results [$];
    int          mismatch_count = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned stall_left = 0;

    fixed_point_alu_q24_8_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_word   (op_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic out_word_t q24_8_compute(in_word_t w);
        out_word_t r;
        longint    a;
        longint    b;
        r = '0;
        a = $signed(w.operand_a);
        b = $signed(w.operand_b);
        case (w.cmd)
            OP_ADD:      r.result = 32'(a + b);
            OP_SUB:      r.result = 32'(a - b);
            OP_NEG:      r.result = 32'(-a);
            OP_MUL:      r.result = 32'((a * b) >>> FRAC);
            OP_DIV:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                    r.result = 32'((a * FIX_ONE) / b);
            end
            OP_GT:       r.compare_true = (a > b);
            OP_GE:       r.compare_true = (a >= b);
            OP_LT:       r.compare_true = (a < b);
            OP_LE:       r.compare_true = (a <= b);
            OP_EQ:       r.compare_true = (a == b);
            OP_NE:       r.compare_true = (a != b);
            OP_MIN:      r.result = 32'((a < b) ? a : b);
            OP_MAX:      r.result = 32'((a < b) ? b : a);
            OP_INC:      r.result = 32'(a + 1);
            OP_DEC:      r.result = 32'(a - 1);
            OP_FROM_INT: r.result = 32'(a * FIX_ONE);
            OP_TO_INT:   r.result = 32'(a / FIX_ONE);
            default:     r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom;
        if (sel < 7)
            return int'($urandom_range(0, 8191)) - 4096;
        if (sel < 8)
            return (int'($urandom_range(0, 255)) - 128) * int'(FIX_ONE);
        case ($urandom_range(0, 5))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return 32'(FIX_ONE);
        endcase
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        if ($urandom_range(0, 19) == 0)
            w.cmd = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else
            w.cmd = 5'($urandom_range(OP_ADD, OP_TO_INT));
        w.operand_a = pick_operand();
        w.operand_b = ($urandom_range(0, 4) == 0) ? w.operand_a : pick_operand();
        return w;
    endfunction

    function automatic int unsigned pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 25;
        endcase
    endfunction

    task automatic issue_word(input in_word_t w, input logic typed, input out_word_t want);
        op_valid <= 1'b1;
        op_word  <= w;
        do @(posedge clk); while (op_stall);
        pending_results.push_back(typed ? want : q24_8_compute(w));
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            op_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: expected result %h cmp %b dz %b, got result %h cmp %b dz %b",
                     what, want.result, want.compare_true, want.divide_by_zero,
                     got.result, got.compare_true, got.divide_by_zero);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_stall  <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 18);
            res_stall  <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected word", ZERO_WORD, res_word);
            else if (res_word.result !== pending_results[0].result
                     || res_word.compare_true !== pending_results[0].compare_true
                     || res_word.divide_by_zero !== pending_results[0].divide_by_zero)
                note_mismatch("word mismatch", pending_results.pop_front(), res_word);
            else
                void'(pending_results.pop_front());
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        op_valid = 1'b0;
        op_word  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 10;
        stall_pct <= 10;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_word(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 100 == 0 || i == QUIET_FROM)
            begin
                gap_pct   = (i >= QUIET_FROM) ? 0 : pick_rate();
                stall_pct <= (i >= QUIET_FROM) ? 0 : pick_rate();
            end
            issue_word(random_word(), 1'b0, ZERO_WORD);
        end
        op_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_div_cell.sv
rtl/fpa_out_buf.sv
rtl/fixed_point_alu_q24_8_core.sv
bench/fixed_point_alu_q24_8_core_tb.sv
